@@ sv/fpi_pkg.sv @@
// Shared types, widths and constant tables for the element power integrator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fpi_pkg;

    localparam int FIELD_BITS  = 24;
    localparam int ACC_BITS    = 48;
    localparam int QUAD_POINTS = 5;
    localparam int OUT_BITS    = 48;
    localparam int MAT_BITS    = 8;
    localparam int PERM_BITS   = 16;
    localparam int FILTER_BITS = 9;

    // stream and register port widths
    localparam int IN_RAW_W    = 7 * FIELD_BITS + MAT_BITS + PERM_BITS;
    localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // datapath widths
    localparam int COEF_FRAC   = 23;
    localparam int COEF_W      = 25;
    localparam int ACC_S_W     = FIELD_BITS + COEF_W + 1;
    localparam int ER_W        = FIELD_BITS + 2;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int HALF_W      = 32;
    localparam int VAL_W       = 64;
    localparam int WIDE_W      = 2 * VAL_W;
    localparam int WQ_W        = 24;
    localparam int RECIP_W     = 57;
    localparam int SQ_W        = 2 * PERM_BITS;
    localparam int POINT_W     = $clog2(QUAD_POINTS);
    localparam int PHASE_W     = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // rounding shifts
    localparam int WEIGHT_SHIFT = 24;
    localparam int LEN_SHIFT    = 20;
    localparam int RECIP_SHIFT  = 40;

    // register indexes (paddr[2])
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_FILTER = 1'b1;

    localparam logic [FILTER_BITS-1:0] FILTER_ALL = '1;

    localparam longint DEC_ONE    = 100000000;
    localparam longint FIVE_POW16 = 64'd152587890625;
    localparam longint FIVE_POW8  = 390625;

    localparam longint GAUSS_POS [QUAD_POINTS] =
        '{-90617985, -53846931, 0, 53846931, 90617985};
    localparam longint GAUSS_WT [QUAD_POINTS] =
        '{23692689, 47862867, 56888889, 47862867, 23692689};

    // quadratic shape function j at Gauss point k, 23 fraction bits
    function automatic logic signed [COEF_W-1:0] shape_coef(input int k, input int j);
        longint a;
        longint b;
        longint num;
        longint mag;
        longint r;
        a = DEC_ONE - GAUSS_POS[k];
        b = DEC_ONE + GAUSS_POS[k];
        if (j == 0)
            num = a * (a - DEC_ONE);
        else if (j == 1)
            num = b * (b - DEC_ONE);
        else
            num = 2 * a * b;
        mag = (num < 0) ? -num : num;
        r = (mag * 64 + FIVE_POW16 / 2) / FIVE_POW16;
        return (num < 0) ? COEF_W'(-r) : COEF_W'(r);
    endfunction

    // half the Gauss weight, 24 fraction bits
    function automatic logic [WQ_W-1:0] weight_q(input int k);
        longint r;
        r = (GAUSS_WT[k] * 32768 + FIVE_POW8 / 2) / FIVE_POW8;
        return WQ_W'(r);
    endfunction

    localparam logic signed [COEF_W-1:0] SHAPE_COEF [QUAD_POINTS][3] = '{
        '{shape_coef(0, 0), shape_coef(0, 1), shape_coef(0, 2)},
        '{shape_coef(1, 0), shape_coef(1, 1), shape_coef(1, 2)},
        '{shape_coef(2, 0), shape_coef(2, 1), shape_coef(2, 2)},
        '{shape_coef(3, 0), shape_coef(3, 1), shape_coef(3, 2)},
        '{shape_coef(4, 0), shape_coef(4, 1), shape_coef(4, 2)}
    };

    localparam logic [WQ_W-1:0] WEIGHT_Q [QUAD_POINTS] = '{
        weight_q(0), weight_q(1), weight_q(2), weight_q(3), weight_q(4)
    };

    // one classified element as it travels from front to back
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] node0_re;
        logic signed [FIELD_BITS-1:0] node0_im;
        logic signed [FIELD_BITS-1:0] node1_re;
        logic signed [FIELD_BITS-1:0] node1_im;
        logic signed [FIELD_BITS-1:0] mid_re;
        logic signed [FIELD_BITS-1:0] mid_im;
        logic [FIELD_BITS-1:0]        element_length;
        logic [PERM_BITS-1:0]         permittivity;
        logic                         keep;
        logic                         last;
        logic                         tm;
    } item_t;

endpackage

`default_nettype wire

@@ sv/fem_element_power_integrator.sv @@
// Element power integrator: 5-point Gauss-Legendre power sum over 1-D elements.
// A kept element occupies the back end through quadrature, length scaling and the add,
// plus reciprocal scaling in transverse magnetic (TM) but not transverse electric (TE) mode;
// a filtered-out element is popped without computation and, if last, goes straight to emit.
// A two-entry queue keeps accepting while the back end works.
// Reset clears sum, clip flag and output valid; mode resets to TM, filter to all materials.
`default_nettype none

module fem_element_power_integrator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fpi_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [fpi_pkg::DATA_W-1:0]     pwdata,
    output logic      [fpi_pkg::DATA_W-1:0]     prdata,
    output logic                                pready,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // node0_re, node0_im, node1_re, node1_im, mid_re, mid_im, element_length,
    // material_id, permittivity
    input  wire logic [fpi_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // total_power
    output logic      [fpi_pkg::OUT_DATA_W-1:0] m_tdata,
    // saturated
    output logic                                m_tuser
);
    import fpi_pkg::*;

    logic                 push;
    item_t                push_item;
    logic                 full;
    logic                 pop;
    item_t                head;
    logic                 empty;
    logic                 recip_start;
    logic                 recip_done;
    logic [RECIP_W-1:0]   recip_value;
    logic [OUT_BITS-1:0]  total_power;

    assign pready  = 1'b1;
    assign m_tdata = OUT_DATA_W'(total_power);

    fpi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    fpi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    fpi_recip u_recip (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (recip_start),
        .permittivity (head.permittivity),
        .done         (recip_done),
        .recip        (recip_value)
    );

    fpi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .recip_start (recip_start),
        .recip_done  (recip_done),
        .recip_value (recip_value),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .total_power (total_power),
        .saturated   (m_tuser)
    );

endmodule

`default_nettype wire

@@ sv/fpi_front.sv @@
// Front end: configuration registers, element unpacking and material filter.
// Depends on fpi_pkg; feeds fpi_queue.
`default_nettype none

module fpi_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpi_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [fpi_pkg::DATA_W-1:0]    pwdata,
    output logic      [fpi_pkg::DATA_W-1:0]    prdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fpi_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic                          full,
    output logic                               push,
    output fpi_pkg::item_t                     push_item
);
    import fpi_pkg::*;

    logic                   mode_reg;
    logic [FILTER_BITS-1:0] filter_reg;
    logic                   cfg_wr;
    logic [MAT_BITS-1:0]    material;

    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            filter_reg <= FILTER_ALL;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_FILTER: filter_reg <= pwdata[FILTER_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE:   prdata = DATA_W'(mode_reg);
            REG_FILTER: prdata = DATA_W'(filter_reg);
        endcase
    end

    assign s_tready = ~full;
    assign push     = s_tvalid & ~full;
    assign material = s_tdata[7*FIELD_BITS +: MAT_BITS];

    always_comb
    begin
        push_item.node0_re       = s_tdata[0*FIELD_BITS +: FIELD_BITS];
        push_item.node0_im       = s_tdata[1*FIELD_BITS +: FIELD_BITS];
        push_item.node1_re       = s_tdata[2*FIELD_BITS +: FIELD_BITS];
        push_item.node1_im       = s_tdata[3*FIELD_BITS +: FIELD_BITS];
        push_item.mid_re         = s_tdata[4*FIELD_BITS +: FIELD_BITS];
        push_item.mid_im         = s_tdata[5*FIELD_BITS +: FIELD_BITS];
        push_item.element_length = s_tdata[6*FIELD_BITS +: FIELD_BITS];
        push_item.permittivity   = s_tdata[7*FIELD_BITS+MAT_BITS +: PERM_BITS];
        // all-ones filter takes every element, other negatives match nothing
        push_item.keep = (filter_reg == FILTER_ALL) ||
                         (!filter_reg[FILTER_BITS-1] &&
                          (filter_reg[MAT_BITS-1:0] == material));
        push_item.last = s_tlast;
        push_item.tm   = ~mode_reg;
    end

endmodule

`default_nettype wire

@@ sv/fpi_queue.sv @@
// Short queue of classified elements between front and back.
// Depends on fpi_pkg.
`default_nettype none

module fpi_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire fpi_pkg::item_t push_item,
    output logic          full,
    input  wire logic     pop,
    output fpi_pkg::item_t head,
    output logic          empty
);
    import fpi_pkg::*;

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ sv/fpi_recip.sv @@
// Reciprocal unit: round(2^56 / p^2) by restoring division, one bit a cycle.
// Depends on fpi_pkg; started by fpi_back.
`default_nettype none

module fpi_recip (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [fpi_pkg::PERM_BITS-1:0]     permittivity,
    output logic                                   done,
    output logic      [fpi_pkg::RECIP_W-1:0]       recip
);
    import fpi_pkg::*;

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_LOAD = 3'b010,
        R_RUN  = 3'b100
    } r_state_t;

    localparam int CNT_W = $clog2(RECIP_W);

    r_state_t             state_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [RECIP_W-1:0]   num_reg;
    logic [SQ_W:0]        rem_reg;
    logic [RECIP_W-1:0]   quo_reg;
    logic [PERM_BITS-1:0] pv;
    logic [SQ_W+1:0]      trial;
    logic                 fits;

    // zero permittivity behaves as one
    assign pv    = (permittivity == '0) ? PERM_BITS'(1) : permittivity;
    assign trial = {rem_reg, num_reg[RECIP_W-1]};
    assign fits  = (trial >= (SQ_W+2)'(sq_reg));
    assign done  = done_reg;
    assign recip = quo_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                    sq_reg <= pv * pv;
            end
            R_LOAD:
            begin
                num_reg <= (RECIP_W'(1) << (RECIP_W - 1)) + RECIP_W'(sq_reg >> 1);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            R_RUN:
            begin
                rem_reg <= fits ? (SQ_W+1)'(trial - (SQ_W+2)'(sq_reg)) : trial[SQ_W:0];
                quo_reg <= {quo_reg[RECIP_W-2:0], fits};
                num_reg <= num_reg << 1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= R_LOAD;
                        done_reg  <= 1'b0;
                    end
                end
                R_LOAD:
                begin
                    cnt_reg   <= CNT_W'(RECIP_W - 1);
                    state_reg <= R_RUN;
                end
                R_RUN:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= R_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/fpi_back.sv @@
// Back end: quadrature sequencer on one shared 33x33 multiplier, length and
// permittivity scaling, saturating accumulator and output register. Uses fpi_pkg.
`default_nettype none

module fpi_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          empty,
    input  wire fpi_pkg::item_t                head,
    output logic                               pop,
    output logic                               recip_start,
    input  wire logic                          recip_done,
    input  wire logic [fpi_pkg::RECIP_W-1:0]   recip_value,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [fpi_pkg::OUT_BITS-1:0]  total_power,
    output logic                               saturated
);
    import fpi_pkg::*;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_POINT = 6'b000010,
        B_LEN   = 6'b000100,
        B_TM    = 6'b001000,
        B_ADD   = 6'b010000,
        B_EMIT  = 6'b100000
    } b_state_t;

    // round(w / 2^s), all ones when the result leaves 64 bits
    function automatic logic [VAL_W-1:0] round_sat(input logic [WIDE_W-1:0] w, input int s);
        logic [WIDE_W-1:0] t;
        t = w + (WIDE_W'(1) << (s - 1));
        if ((t >> (s + VAL_W)) != '0)
            return '1;
        return VAL_W'(t >> s);
    endfunction

    // magnitude rounded to 20 fraction bits
    function automatic logic [ER_W-1:0] round_mag(input logic signed [ACC_S_W-1:0] v);
        logic [ACC_S_W-1:0] mag;
        mag = v[ACC_S_W-1] ? ACC_S_W'(-v) : ACC_S_W'(v);
        mag = mag + (ACC_S_W'(1) << (COEF_FRAC - 1));
        return ER_W'(mag >> COEF_FRAC);
    endfunction

    b_state_t                  state_reg,  state_next;
    item_t                     item_reg,   item_next;
    logic [POINT_W-1:0]        k_reg,      k_next;
    logic [PHASE_W-1:0]        ph_reg,     ph_next;
    logic signed [ACC_S_W-1:0] acc_reg,    acc_next;
    logic [ER_W-1:0]           er_reg,     er_next;
    logic [ER_W-1:0]           ei_reg,     ei_next;
    logic [VAL_W-1:0]          esq_reg,    esq_next;
    logic [WIDE_W-1:0]         wide_reg,   wide_next;
    logic [VAL_W-1:0]          elem_reg,   elem_next;
    logic [VAL_W-1:0]          pval_reg,   pval_next;
    logic [ACC_BITS-1:0]       sum_reg,    sum_next;
    logic                      clip_reg,   clip_next;
    logic                      oval_reg,   oval_next;
    logic [OUT_BITS-1:0]       opow_reg,   opow_next;
    logic                      osat_reg,   osat_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [VAL_W-1:0]          prod_u;
    logic [VAL_W-1:0]          rcp;
    logic [ACC_BITS-1:0]       room;

    assign prod_u = prod_reg[VAL_W-1:0];
    assign rcp    = VAL_W'(recip_value);
    assign room   = ~sum_reg;

    assign m_tvalid    = oval_reg;
    assign total_power = opow_reg;
    assign saturated   = osat_reg;

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        k_next      = k_reg;
        ph_next     = ph_reg;
        acc_next    = acc_reg;
        er_next     = er_reg;
        ei_next     = ei_reg;
        esq_next    = esq_reg;
        wide_next   = wide_reg;
        elem_next   = elem_reg;
        pval_next   = pval_reg;
        sum_next    = sum_reg;
        clip_next   = clip_reg;
        oval_next   = oval_reg & ~m_tready;
        opow_next   = opow_reg;
        osat_next   = osat_reg;
        pop         = 1'b0;
        recip_start = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    item_next = head;
                    if (head.keep)
                    begin
                        recip_start = head.tm;
                        k_next      = '0;
                        ph_next     = '0;
                        elem_next   = '0;
                        state_next  = B_POINT;
                    end
                    else if (head.last)
                        state_next = B_EMIT;
                end
            end

            B_POINT:
            begin
                ph_next = ph_reg + 1'b1;
                unique case (ph_reg)
                    4'd0:
                    begin
                        mul_a = MUL_W'(item_reg.node0_re);
                        mul_b = MUL_W'(SHAPE_COEF[k_reg][0]);
                    end
                    4'd1:
                    begin
                        mul_a    = MUL_W'(item_reg.node1_re);
                        mul_b    = MUL_W'(SHAPE_COEF[k_reg][1]);
                        acc_next = ACC_S_W'(prod_reg);
                    end
                    4'd2:
                    begin
                        mul_a    = MUL_W'(item_reg.mid_re);
                        mul_b    = MUL_W'(SHAPE_COEF[k_reg][2]);
                        acc_next = acc_reg + ACC_S_W'(prod_reg);
                    end
                    4'd3:
                    begin
                        mul_a    = MUL_W'(item_reg.node0_im);
                        mul_b    = MUL_W'(SHAPE_COEF[k_reg][0]);
                        acc_next = acc_reg + ACC_S_W'(prod_reg);
                    end
                    4'd4:
                    begin
                        // real part complete: round it, start the imaginary sum
                        mul_a    = MUL_W'(item_reg.node1_im);
                        mul_b    = MUL_W'(SHAPE_COEF[k_reg][1]);
                        er_next  = round_mag(acc_reg);
                        acc_next = ACC_S_W'(prod_reg);
                    end
                    4'd5:
                    begin
                        mul_a    = MUL_W'(item_reg.mid_im);
                        mul_b    = MUL_W'(SHAPE_COEF[k_reg][2]);
                        acc_next = acc_reg + ACC_S_W'(prod_reg);
                    end
                    4'd6:
                    begin
                        mul_a    = MUL_W'(er_reg);
                        mul_b    = MUL_W'(er_reg);
                        acc_next = acc_reg + ACC_S_W'(prod_reg);
                    end
                    4'd7:
                    begin
                        ei_next  = round_mag(acc_reg);
                        esq_next = prod_u;
                    end
                    4'd8:
                    begin
                        mul_a = MUL_W'(ei_reg);
                        mul_b = MUL_W'(ei_reg);
                    end
                    4'd9:
                    begin
                        esq_next = esq_reg + prod_u;
                    end
                    4'd10:
                    begin
                        mul_a = MUL_W'(esq_reg[HALF_W-1:0]);
                        mul_b = MUL_W'(WEIGHT_Q[k_reg]);
                    end
                    4'd11:
                    begin
                        mul_a     = MUL_W'(esq_reg[VAL_W-1:HALF_W]);
                        mul_b     = MUL_W'(WEIGHT_Q[k_reg]);
                        wide_next = WIDE_W'(prod_u);
                    end
                    4'd12:
                    begin
                        wide_next = wide_reg + (WIDE_W'(prod_u) << HALF_W);
                    end
                    4'd13:
                    begin
                        elem_next = elem_reg + round_sat(wide_reg, WEIGHT_SHIFT);
                        ph_next   = '0;
                        if (k_reg == POINT_W'(QUAD_POINTS - 1))
                            state_next = B_LEN;
                        else
                            k_next = k_reg + 1'b1;
                    end
                    default: ph_next = '0;
                endcase
            end

            B_LEN:
            begin
                ph_next = ph_reg + 1'b1;
                unique case (ph_reg)
                    4'd0:
                    begin
                        mul_a = MUL_W'(elem_reg[HALF_W-1:0]);
                        mul_b = MUL_W'(item_reg.element_length);
                    end
                    4'd1:
                    begin
                        mul_a     = MUL_W'(elem_reg[VAL_W-1:HALF_W]);
                        mul_b     = MUL_W'(item_reg.element_length);
                        wide_next = WIDE_W'(prod_u);
                    end
                    4'd2:
                    begin
                        wide_next = wide_reg + (WIDE_W'(prod_u) << HALF_W);
                    end
                    4'd3:
                    begin
                        pval_next  = round_sat(wide_reg, LEN_SHIFT);
                        ph_next    = '0;
                        state_next = item_reg.tm ? B_TM : B_ADD;
                    end
                    default: ph_next = '0;
                endcase
            end

            B_TM:
            begin
                ph_next = ph_reg + 1'b1;
                unique case (ph_reg)
                    4'd0:
                    begin
                        // hold until the reciprocal is ready
                        mul_a = MUL_W'(pval_reg[HALF_W-1:0]);
                        mul_b = MUL_W'(rcp[HALF_W-1:0]);
                        if (!recip_done)
                            ph_next = ph_reg;
                    end
                    4'd1:
                    begin
                        mul_a     = MUL_W'(pval_reg[HALF_W-1:0]);
                        mul_b     = MUL_W'(rcp[VAL_W-1:HALF_W]);
                        wide_next = WIDE_W'(prod_u);
                    end
                    4'd2:
                    begin
                        mul_a     = MUL_W'(pval_reg[VAL_W-1:HALF_W]);
                        mul_b     = MUL_W'(rcp[HALF_W-1:0]);
                        wide_next = wide_reg + (WIDE_W'(prod_u) << HALF_W);
                    end
                    4'd3:
                    begin
                        mul_a     = MUL_W'(pval_reg[VAL_W-1:HALF_W]);
                        mul_b     = MUL_W'(rcp[VAL_W-1:HALF_W]);
                        wide_next = wide_reg + (WIDE_W'(prod_u) << HALF_W);
                    end
                    4'd4:
                    begin
                        wide_next = wide_reg + (WIDE_W'(prod_u) << VAL_W);
                    end
                    4'd5:
                    begin
                        pval_next  = round_sat(wide_reg, RECIP_SHIFT);
                        ph_next    = '0;
                        state_next = B_ADD;
                    end
                    default: ph_next = '0;
                endcase
            end

            B_ADD:
            begin
                // headroom below an all-ones limit is the complement of the sum
                if (pval_reg > VAL_W'(room))
                begin
                    sum_next  = '1;
                    clip_next = 1'b1;
                end
                else
                    sum_next = sum_reg + ACC_BITS'(pval_reg);
                state_next = item_reg.last ? B_EMIT : B_IDLE;
            end

            B_EMIT:
            begin
                if (!oval_reg || m_tready)
                begin
                    oval_next  = 1'b1;
                    opow_next  = OUT_BITS'(sum_reg);
                    osat_next  = clip_reg;
                    sum_next   = '0;
                    clip_next  = 1'b0;
                    state_next = B_IDLE;
                end
            end

            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        item_reg <= item_next;
        acc_reg  <= acc_next;
        er_reg   <= er_next;
        ei_reg   <= ei_next;
        esq_reg  <= esq_next;
        wide_reg <= wide_next;
        elem_reg <= elem_next;
        pval_reg <= pval_next;
        opow_reg <= opow_next;
        osat_reg <= osat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            k_reg     <= '0;
            ph_reg    <= '0;
            sum_reg   <= '0;
            clip_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
            sum_reg   <= sum_next;
            clip_reg  <= clip_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/fem_element_power_integrator_tb.sv @@
// Testbench for the element power integrator: stream stimulus, APB register setup,
// and a bit-true predictor of the quadrature power sum. Depends on fpi_pkg and the RTL.
`timescale 1ns / 1ps

module fem_element_power_integrator_tb;
    import fpi_pkg::*;

    typedef struct {
        logic signed [FIELD_BITS-1:0] n0r, n0i, n1r, n1i, mr, mi;
        logic [FIELD_BITS-1:0]        len;
        logic [MAT_BITS-1:0]          mat;
        logic [PERM_BITS-1:0]         perm;
        logic                         last;
        bit                           typed;
        logic [OUT_BITS-1:0]          t_pow;
        logic                         t_sat;
    } elem_t;

    typedef struct {
        logic [OUT_BITS-1:0] pow;
        logic                sat;
    } mesh_total_t;

    localparam longint PT_POS [QUAD_POINTS] =
        '{-90617985, -53846931, 0, 53846931, 90617985};
    localparam longint PT_WT [QUAD_POINTS] =
        '{23692689, 47862867, 56888889, 47862867, 23692689};
    localparam logic [63:0] SUM_MAX = (64'd1 << ACC_BITS) - 1;
    localparam int DRAIN_CYCLES = 120;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;

    // predictor state
    logic                   te_mode;
    logic [FILTER_BITS-1:0] mat_filter;
    logic [63:0]            power_acc;
    logic                   clipped;
    mesh_total_t            total_q[$];

    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;

    fem_element_power_integrator u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("fem_element_power_integrator_tb: errors");
        $finish;
    end

    function automatic longint shape_val(input int k, input int j);
        longint a, b, num, mag, r;
        a = 100000000 - PT_POS[k];
        b = 100000000 + PT_POS[k];
        if (j == 0)
            num = a * (a - 100000000);
        else if (j == 1)
            num = b * (b - 100000000);
        else
            num = 2 * a * b;
        mag = (num < 0) ? -num : num;
        r = (mag * 64 + 64'd152587890625 / 2) / 64'd152587890625;
        return (num < 0) ? -r : r;
    endfunction

    // rounded magnitude of one interpolated component, 20 fraction bits
    function automatic logic [63:0] comp_mag(input int k, input logic signed [FIELD_BITS-1:0] f0,
                                             input logic signed [FIELD_BITS-1:0] f1,
                                             input logic signed [FIELD_BITS-1:0] f2);
        longint s;
        logic [63:0] mag;
        s = longint'(f0) * shape_val(k, 0) + longint'(f1) * shape_val(k, 1)
            + longint'(f2) * shape_val(k, 2);
        mag = (s < 0) ? 64'(-s) : 64'(s);
        return (mag + (64'd1 << 22)) >> 23;
    endfunction

    function automatic logic [63:0] add_clamp(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] z;
        z = {1'b0, x} + {1'b0, y};
        return z[64] ? '1 : z[63:0];
    endfunction

    function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [128:0] full;
        full = {65'd0, a};
        full = full * {65'd0, b};
        full = full + (129'd1 << (s - 1));
        full = full >> s;
        return (full[128:64] != 0) ? '1 : full[63:0];
    endfunction

    task automatic accumulate_element(input elem_t e);
        logic [63:0] elem, p, er, ei, wq, pv, recip;
        bit keep;
        mesh_total_t t;
        keep = (mat_filter == FILTER_ALL) ||
               (!mat_filter[FILTER_BITS-1] && mat_filter[MAT_BITS-1:0] == e.mat);
        if (keep)
        begin
            elem = 0;
            for (int k = 0; k < QUAD_POINTS; k++)
            begin
                er = comp_mag(k, e.n0r, e.n1r, e.mr);
                ei = comp_mag(k, e.n0i, e.n1i, e.mi);
                wq = (64'(PT_WT[k]) * 32768 + 390625 / 2) / 390625;
                elem = add_clamp(elem, mul_round(add_clamp(er * er, ei * ei), wq, WEIGHT_SHIFT));
            end
            p = mul_round(elem, 64'(e.len), LEN_SHIFT);
            if (!te_mode)
            begin
                pv = (e.perm == 0) ? 64'd1 : 64'(e.perm);
                recip = ((64'd1 << 56) + (pv * pv) / 2) / (pv * pv);
                p = mul_round(p, recip, RECIP_SHIFT);
            end
            if (p > SUM_MAX - power_acc)
            begin
                power_acc = SUM_MAX;
                clipped = 1'b1;
            end
            else
                power_acc = power_acc + p;
        end
        if (e.last)
        begin
            t.pow = e.typed ? e.t_pow : power_acc[OUT_BITS-1:0];
            t.sat = e.typed ? e.t_sat : clipped;
            total_q.push_back(t);
            power_acc = 0;
            clipped = 1'b0;
        end
    endtask

    // hold the word until accepted; valid stays high into the next word when no gap
    task automatic send_element(input elem_t e);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle)
                @(negedge clk);
        end
        s_tdata <= {e.perm, e.mat, e.len, e.mi, e.mr, e.n1i, e.n1r, e.n0i, e.n0r};
        s_tlast <= e.last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accumulate_element(e);
        @(negedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_MODE)
            te_mode = value[0];
        else
            mat_filter = value[FILTER_BITS-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        wait (total_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [FIELD_BITS-1:0] pick_field();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return '0;
            3: return 24'($urandom_range(4095)) - 24'd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        mesh_total_t t;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (total_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected total %h sat %b", m_tdata[OUT_BITS-1:0], m_tuser);
            end
            else
            begin
                t = total_q.pop_front();
                if (m_tdata[OUT_BITS-1:0] !== t.pow || m_tuser !== t.sat)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h/%b got %h/%b", t.pow, t.sat,
                                 m_tdata[OUT_BITS-1:0], m_tuser);
                end
            end
        end
    end

    initial
    begin
        elem_t rows[$];
        elem_t e;
        logic [1:0]         ph_mode [6];
        logic [FILTER_BITS-1:0] ph_filt [6];
        int n;

        te_mode = 1'b0;
        mat_filter = FILTER_ALL;
        power_acc = 0;
        clipped = 1'b0;

        // directed rows: zero field, extremes, zero length, then predicted meshes
        e = '{default: '0};
        e.perm = 16'd256; e.last = 1; e.typed = 1; e.t_pow = 0; e.t_sat = 0;
        rows.push_back(e);
        e = '{default: '0};
        {e.n0r, e.n0i, e.n1r, e.n1i, e.mr, e.mi} = {6{24'h7FFFFF}};
        e.len = '1; e.perm = 1; e.last = 1; e.typed = 1; e.t_pow = '1; e.t_sat = 1;
        rows.push_back(e);
        {e.n0r, e.n0i, e.n1r, e.n1i, e.mr, e.mi} = {6{24'h800000}};
        e.mat = 8'hFF;
        rows.push_back(e);
        e = '{default: '0};
        e.len = '1; e.perm = '1; e.last = 1; e.typed = 1; e.t_pow = 0; e.t_sat = 0;
        rows.push_back(e);
        e = '{default: '0};
        {e.n0r, e.n0i, e.n1r, e.n1i, e.mr, e.mi} = {24'h7FFFFF, 24'h800000, 24'h123456,
                                                    24'hFEDCBA, 24'h7FFFFF, 24'h800000};
        e.perm = 1; e.last = 1; e.typed = 1; e.t_pow = 0; e.t_sat = 0;
        rows.push_back(e);
        for (int i = 0; i < 14; i++)
        begin
            e = '{default: '0};
            {e.n0r, e.n0i, e.n1r, e.n1i, e.mr, e.mi} =
                {pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
                 pick_field()};
            e.len = (i % 3 == 0) ? '1 : 24'(1 << 20);
            e.perm = (i % 2) ? 16'hFFFF : 16'd256 + 16'(i);
            e.mat = 8'(i * 37);
            e.last = (i % 4 == 3) || (i == 13);
            rows.push_back(e);
        end

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle = 17;
        recv_idle = 76;
        foreach (rows[i])
            send_element(rows[i]);
        drain();

        ph_mode = '{0, 1, 0, 1, 1, 0};
        ph_filt = '{9'h1FF, 9'h1FF, 9'h000, 9'h0FF, 9'h1FE, 9'h100};
        n = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(REG_MODE, {31'd0, ph_mode[ph][0]});
            reg_write(REG_FILTER, {23'd0, ph_filt[ph]});
            for (int i = 0; i < 125; i++)
            begin
                if (n < 250)
                begin
                    send_idle = 17;
                    recv_idle = 76;
                end
                else if (n < 500)
                begin
                    send_idle = 76;
                    recv_idle = 17;
                end
                else
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                e = '{default: '0};
                {e.n0r, e.n0i, e.n1r, e.n1i, e.mr, e.mi} =
                    {pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
                     pick_field()};
                case ($urandom_range(5))
                    0: e.len = '0;
                    1: e.len = '1;
                    2: e.len = 24'($urandom_range(1 << 18));
                    default: e.len = 24'($urandom);
                endcase
                case ($urandom_range(4))
                    0: e.perm = 16'd1;
                    1: e.perm = 16'hFFFF;
                    2: e.perm = 16'($urandom_range(512, 1));
                    default: e.perm = 16'($urandom_range(65535, 1));
                endcase
                // favor elements that pass the filter
                e.mat = ($urandom_range(1)) ? ph_filt[ph][MAT_BITS-1:0] : 8'($urandom);
                e.last = ($urandom_range(7) == 0) || (i == 124);
                send_element(e);
                n++;
            end
            drain();
        end

        if (errors == 0 && total_q.size() == 0)
            $display("fem_element_power_integrator_tb: clean");
        else
            $display("fem_element_power_integrator_tb: errors");
        $finish;
    end

endmodule
